// File: rtl/ble_midi_packetizer_defines.svh
// Assertion macros for the BLE MIDI packetizer.
// Included by the top level; expects clk and arst_n in the including scope.
`ifndef BLE_MIDI_PACKETIZER_DEFINES_SVH
`define BLE_MIDI_PACKETIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define BMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bmp_pkg.sv
// Shared types and constants for the BLE MIDI packetizer.
// No dependencies; used by ble_midi_packetizer.
`default_nettype none

package bmp_pkg;

	// Command codes carried on the input tuser.
	localparam logic [2:0] CMD_PUSH  = 3'd0;
	localparam logic [2:0] CMD_TICK  = 3'd1;
	localparam logic [2:0] CMD_SYNC  = 3'd2;
	localparam logic [2:0] CMD_REQ   = 3'd3;
	localparam logic [2:0] CMD_CLEAR = 3'd4;

	// Result kinds carried on the output tuser.
	localparam logic [1:0] KIND_PUSH   = 2'd0;
	localparam logic [1:0] KIND_BYTE   = 2'd1;
	localparam logic [1:0] KIND_NO_PKT = 2'd2;

	// Configuration register indexes.
	localparam logic REG_MAX_PACKET_LEN = 1'b0;
	localparam logic REG_RS_ENABLE      = 1'b1;

	// Register reset values.
	localparam logic [6:0] MAX_LEN_RESET = 7'd20;
	localparam logic       RS_EN_RESET   = 1'b1;

	// Timestamp counter limit and message length in bytes.
	localparam logic [12:0] STAMP_MAX = 13'h1fff;
	localparam int          MSG_LEN   = 3;

	// Packet builder states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SKIP,
		ST_LOOP,
		ST_STAT,
		ST_DATA,
		ST_FIN
	} bmp_state_t;

	// One queued entry: the MIDI byte and the tick it arrived on.
	typedef struct packed {
		logic [12:0] stamp;
		logic [7:0]  data;
	} bmp_entry_t;

endpackage

`default_nettype wire

// File: rtl/ble_midi_packetizer.sv
// BLE MIDI packetizer: MIDI byte FIFO with timestamps and a packet builder.
// Depends on bmp_pkg and ble_midi_packetizer_defines.svh.
//
// Commands arrive one per input transfer. Push, tick, sync, clear and unknown
// codes are handled in the idle state; a push returns one status transfer. A
// packet request walks the FIFO memory through its single registered read
// port, which always holds the current front entry, so the builder steps
// through the queued bytes in order, waiting while the output register cannot
// be loaded: it skips orphan bytes, emits data bytes, leaves out status bytes
// as running status and adds a start and a finish step. The last packet byte
// leaves once the builder knows the packet has ended. Input is taken only
// between requests and while the output register can be loaded. The FIFO
// memory has no clearing pass; it is usable right after reset.
`default_nettype none

`include "ble_midi_packetizer_defines.svh"

module ble_midi_packetizer #(
	parameter int FIFO_DEPTH = 128,
	parameter int MAX_PACKET = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write port.
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [6:0]  cfg_data,
	// Command stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,  // [7:0] midi_byte, [21:8] sync_value
	input  wire logic [2:0]  s_axis_tuser,  // [2:0] cmd
	// Result stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,  // [7:0] data_byte, [8] accepted,
	                                        // [15:9] packet_len, [16] more_pending
	output logic [1:0]       m_axis_tuser,  // [1:0] kind
	output logic             m_axis_tlast
);

	localparam int PtrW = $clog2(FIFO_DEPTH);
	localparam int FillW = $clog2(FIFO_DEPTH + 1);
	localparam logic [6:0] MaxPkt = 7'(MAX_PACKET);

	// Configuration registers.
	logic [6:0] max_len_q;
	logic       rs_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= bmp_pkg::MAX_LEN_RESET;
			rs_en_q   <= bmp_pkg::RS_EN_RESET;
		end else if (cfg_we) begin
			if (cfg_addr == bmp_pkg::REG_MAX_PACKET_LEN) begin
				max_len_q <= cfg_data;
			end else begin
				rs_en_q <= cfg_data[0];
			end
		end
	end

	// Effective packet limit.
	logic [6:0] lim;
	assign lim = (max_len_q < MaxPkt) ? max_len_q : MaxPkt;

	// State registers.
	bmp_pkg::bmp_state_t state_q, state_d;
	logic [PtrW-1:0]  rp_q, rp_d, wp_q, wp_d;
	logic [FillW-1:0] fill_q, fill_d;
	logic [12:0]      tick_q;
	logic [7:0]       rs_q;
	logic [12:0]      last_ts_q;
	logic [6:0]       n_q;
	logic [7:0]       pend_q;
	logic             pend_v_q;
	logic             ld_ts_q;

	// Output register.
	logic       out_valid_q;
	logic [1:0] out_kind_q;
	logic [7:0] out_byte_q;
	logic       out_acc_q;
	logic       out_last_q;
	logic [6:0] out_len_q;
	logic       out_more_q;

	// FIFO memory with the front entry always registered at its read port.
	bmp_pkg::bmp_entry_t mem [FIFO_DEPTH];
	bmp_pkg::bmp_entry_t front_q;
	bmp_pkg::bmp_entry_t wr_entry;

	// Shared conditions.
	logic       out_free, in_fire;
	logic       front_stat, fill_ge3, fill_full, loop_ok, rs_hit;
	logic       st_rs_go, st_new_go, skip_ok, skip_drop, skip_hdr, data_ok;
	logic [6:0] n_plus2, n_plus4;

	assign out_free  = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == bmp_pkg::ST_IDLE) && out_free;
	assign in_fire   = s_axis_tvalid && s_axis_tready;

	assign front_stat = front_q.data[7];
	assign fill_ge3   = fill_q >= FillW'(bmp_pkg::MSG_LEN);
	assign fill_full  = fill_q == FillW'(FIFO_DEPTH);
	assign loop_ok    = (n_q < lim) && (fill_q != '0);
	assign rs_hit     = (front_q.data == rs_q) && (front_q.stamp == last_ts_q);
	assign n_plus2    = n_q + 7'd2;
	assign n_plus4    = n_q + 7'd4;
	assign st_rs_go   = fill_ge3 && rs_hit && (n_plus2 < lim);
	assign st_new_go  = fill_ge3 && !rs_hit && (n_plus4 < lim);
	assign skip_ok    = (lim != '0) && (fill_q != '0);
	assign skip_drop  = !front_stat && (fill_q > FillW'(1));
	assign skip_hdr   = !skip_drop && fill_ge3;
	assign data_ok    = n_q < MaxPkt;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmp_pkg::ST_IDLE: begin
				if (in_fire && s_axis_tuser == bmp_pkg::CMD_REQ) begin
					state_d = bmp_pkg::ST_SKIP;
				end
			end
			bmp_pkg::ST_SKIP: begin
				if (out_free) begin
					if (!skip_ok) begin
						state_d = bmp_pkg::ST_FIN;
					end else if (skip_drop) begin
						state_d = bmp_pkg::ST_SKIP;
					end else if (skip_hdr) begin
						state_d = bmp_pkg::ST_STAT;
					end else begin
						state_d = bmp_pkg::ST_FIN;
					end
				end
			end
			bmp_pkg::ST_LOOP: begin
				if (out_free) begin
					if (!loop_ok) begin
						state_d = bmp_pkg::ST_FIN;
					end else if (front_stat) begin
						state_d = (st_rs_go || st_new_go) ? bmp_pkg::ST_DATA : bmp_pkg::ST_FIN;
					end else begin
						state_d = data_ok ? bmp_pkg::ST_LOOP : bmp_pkg::ST_FIN;
					end
				end
			end
			bmp_pkg::ST_STAT: begin
				if (out_free) begin
					state_d = (st_rs_go || st_new_go) ? bmp_pkg::ST_DATA : bmp_pkg::ST_FIN;
				end
			end
			bmp_pkg::ST_DATA: begin
				if (out_free) begin
					state_d = data_ok ? bmp_pkg::ST_LOOP : bmp_pkg::ST_FIN;
				end
			end
			bmp_pkg::ST_FIN: begin
				if (out_free) begin
					state_d = bmp_pkg::ST_IDLE;
				end
			end
			default: state_d = bmp_pkg::ST_IDLE;
		endcase
	end

	// Datapath controls.
	logic       do_push, do_drop, do_clear, do_tick, do_sync, do_start, do_fin;
	logic       stat_step, emit_en, rs_load, ts_load;
	logic [7:0] emit_byte;
	logic       out_load;
	logic [1:0] o_kind;
	logic [7:0] o_byte;
	logic       o_acc, o_last, o_more;
	logic [6:0] o_len;

	always_comb begin
		do_push   = 1'b0;
		do_drop   = 1'b0;
		do_clear  = 1'b0;
		do_tick   = 1'b0;
		do_sync   = 1'b0;
		do_start  = 1'b0;
		do_fin    = 1'b0;
		stat_step = 1'b0;
		emit_en   = 1'b0;
		emit_byte = front_q.data;
		rs_load   = 1'b0;
		ts_load   = 1'b0;
		case (state_q)
			bmp_pkg::ST_IDLE: begin
				if (in_fire) begin
					case (s_axis_tuser)
						bmp_pkg::CMD_PUSH:  do_push  = !fill_full;
						bmp_pkg::CMD_TICK:  do_tick  = 1'b1;
						bmp_pkg::CMD_SYNC:  do_sync  = 1'b1;
						bmp_pkg::CMD_REQ:   do_start = 1'b1;
						bmp_pkg::CMD_CLEAR: do_clear = 1'b1;
						default: ;
					endcase
				end
			end
			bmp_pkg::ST_SKIP: begin
				if (out_free && skip_ok) begin
					if (skip_drop) begin
						do_drop = 1'b1;
					end else if (skip_hdr) begin
						emit_en   = 1'b1;
						emit_byte = {2'b10, front_q.stamp[12:7]};
					end
				end
			end
			bmp_pkg::ST_LOOP: begin
				if (out_free && loop_ok) begin
					if (front_stat) begin
						stat_step = 1'b1;
					end else if (data_ok) begin
						do_drop = 1'b1;
						emit_en = 1'b1;
					end
				end
			end
			bmp_pkg::ST_STAT: begin
				stat_step = out_free;
			end
			bmp_pkg::ST_DATA: begin
				if (out_free && data_ok) begin
					do_drop = 1'b1;
					emit_en = 1'b1;
				end
			end
			bmp_pkg::ST_FIN: begin
				do_fin = out_free;
			end
			default: ;
		endcase

		// Status byte: running status drops it, a new status gets a timestamp byte.
		if (stat_step) begin
			rs_load = fill_ge3 && !rs_hit && rs_en_q;
			if (st_rs_go) begin
				do_drop = 1'b1;
			end else if (st_new_go) begin
				ts_load   = 1'b1;
				emit_en   = 1'b1;
				emit_byte = {1'b1, front_q.stamp[6:0]};
			end
		end
	end

	// Result selection: push status, a held packet byte, or the packet end.
	always_comb begin
		out_load = 1'b0;
		o_kind   = bmp_pkg::KIND_BYTE;
		o_byte   = pend_q;
		o_acc    = 1'b0;
		o_last   = 1'b0;
		o_len    = '0;
		o_more   = 1'b0;
		if (in_fire && s_axis_tuser == bmp_pkg::CMD_PUSH) begin
			out_load = 1'b1;
			o_kind   = bmp_pkg::KIND_PUSH;
			o_byte   = '0;
			o_acc    = !fill_full;
			o_last   = 1'b1;
		end else if (emit_en && pend_v_q) begin
			out_load = 1'b1;
		end else if (do_fin) begin
			out_load = 1'b1;
			o_last   = 1'b1;
			if (pend_v_q) begin
				o_len  = n_q;
				o_more = fill_ge3;
			end else begin
				o_kind = bmp_pkg::KIND_NO_PKT;
				o_byte = '0;
			end
		end
	end

	// Pointer and fill count updates.
	always_comb begin
		rp_d   = rp_q;
		wp_d   = wp_q;
		fill_d = fill_q;
		if (do_clear) begin
			rp_d   = '0;
			wp_d   = '0;
			fill_d = '0;
		end else if (do_push) begin
			wp_d   = (wp_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			fill_d = fill_q + 1'b1;
		end else if (do_drop) begin
			rp_d   = (rp_q == PtrW'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			fill_d = fill_q - 1'b1;
		end
	end

	assign wr_entry.stamp = tick_q;
	assign wr_entry.data  = s_axis_tdata[7:0];

	// Memory write and front read, forwarding a push into an empty FIFO.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wp_q] <= wr_entry;
		end
		if (do_push && wp_q == rp_d) begin
			front_q <= wr_entry;
		end else begin
			front_q <= mem[rp_d];
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= bmp_pkg::ST_IDLE;
			rp_q      <= '0;
			wp_q      <= '0;
			fill_q    <= '0;
			tick_q    <= '0;
			rs_q      <= '0;
			last_ts_q <= '0;
			n_q       <= '0;
			pend_v_q  <= 1'b0;
			ld_ts_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			fill_q  <= fill_d;

			if (do_tick) begin
				tick_q <= (tick_q == bmp_pkg::STAMP_MAX) ? '0 : tick_q + 1'b1;
			end else if (do_sync) begin
				tick_q <= s_axis_tdata[21] ? bmp_pkg::STAMP_MAX : s_axis_tdata[20:8];
			end

			if (do_start || do_clear || do_fin) begin
				rs_q <= '0;
			end else if (rs_load) begin
				rs_q <= front_q.data;
			end

			// Running status compares against the stamp of the byte after it.
			if (do_start) begin
				last_ts_q <= '0;
			end else if (ts_load || (state_q == bmp_pkg::ST_DATA && out_free && ld_ts_q)) begin
				last_ts_q <= front_q.stamp;
			end

			if (stat_step) begin
				ld_ts_q <= st_rs_go;
			end

			if (do_start) begin
				n_q      <= '0;
				pend_v_q <= 1'b0;
			end else if (emit_en) begin
				n_q      <= n_q + 7'd1;
				pend_v_q <= 1'b1;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (emit_en) begin
			pend_q <= emit_byte;
		end
		if (out_load) begin
			out_kind_q <= o_kind;
			out_byte_q <= o_byte;
			out_acc_q  <= o_acc;
			out_last_q <= o_last;
			out_len_q  <= o_len;
			out_more_q <= o_more;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {7'd0, out_more_q, out_len_q, out_acc_q, out_byte_q};

	// Terms used by the checks below.
	logic busy_chk, pkt_end_chk, len_ok_chk, req_fire_chk, started_chk;
	assign busy_chk     = state_q != bmp_pkg::ST_IDLE;
	assign pkt_end_chk  = m_axis_tvalid && m_axis_tlast && m_axis_tuser == bmp_pkg::KIND_BYTE;
	assign len_ok_chk   = (out_len_q != '0) && (out_len_q <= MaxPkt);
	assign req_fire_chk = in_fire && s_axis_tuser == bmp_pkg::CMD_REQ;
	assign started_chk  = state_q == bmp_pkg::ST_SKIP && n_q == '0 && !pend_v_q;

	// Checks on the builder.
	`BMP_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FillW'(FIFO_DEPTH), "fill count above depth")
	`BMP_ASSERT_NOW(a_busy_no_input, busy_chk, !s_axis_tready, "input taken while building")
	`BMP_ASSERT_NOW(a_len_bound, pkt_end_chk, len_ok_chk, "packet length out of range")
	`BMP_ASSERT_NEXT(a_req_starts, req_fire_chk, started_chk, "request did not start a packet")

endmodule

`default_nettype wire
